// ----- src/art_pkg.sv -----
// Package for the ACK range tracker: sizes, word types, state and status codes.
package art_pkg;

    // Depth of the range list and the index and count widths that follow from it
    localparam int MAX_RANGES = 16;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    // Input word
    typedef struct packed {
        logic [31:0] packet_number;
        logic        ack_eliciting;
    } art_in_t;

    // Result word
    typedef struct packed {
        logic        item_kind;
        logic [31:0] largest_ack;
        logic [5:0]  ack_range_count;
        logic [31:0] first_range_length;
        logic [31:0] gap_size;
        logic [31:0] range_length;
        logic [2:0]  update_status;
        logic        last_item;
    } art_out_t;

    // One stored range, start and end inclusive
    typedef struct packed {
        logic [31:0] rstart;
        logic [31:0] rend;
    } range_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_SHIFT,
        ST_FIN,
        ST_EMIT
    } art_state_t;

    // Update status codes
    localparam logic [2:0] UPD_NEW   = 3'd0;
    localparam logic [2:0] UPD_EXT   = 3'd1;
    localparam logic [2:0] UPD_MERGE = 3'd2;
    localparam logic [2:0] UPD_DUP   = 3'd3;
    localparam logic [2:0] UPD_FULL  = 3'd4;

    // Item kinds
    localparam logic KIND_HDR   = 1'b0;
    localparam logic KIND_RANGE = 1'b1;

endpackage

// ----- src/ack_range_tracker.sv -----
// ACK range tracker: range list in a one-port-read memory, walked by a small sequencer.
//
//  channel   | handshake              | word
//  ----------+------------------------+---------------------------
//  command   | start, busy            | cmd    (art_in_t)
//  result    | result_valid (strobe)  | result (art_out_t)
//
// One word runs three walks through the single memory read port, one entry per
// cycle: a scan over the stored ranges, a shift pass over the entries that move,
// and an emit pass over the ranges after the update. Choosing the update comes
// between scan and shift, the final write between shift and emit. The longest
// run is for a new range above all others in a full list. A new word is taken
// only in idle, so not before the results of the last word have all left.
// busy stays high through the cycle that carries the last result; results
// leave one per cycle and cannot be held off.
// After reset the list is empty; no clearing pass is needed.
module ack_range_tracker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  art_pkg::art_in_t  cmd,
    output logic              result_valid,
    output art_pkg::art_out_t result
);
    import art_pkg::*;

    art_state_t state_reg, state_next;

    art_in_t          in_reg, in_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [2:0]       st_reg, st_next;
    logic [CNT_W-1:0] k_reg, k_next;
    range_t           lo_reg, lo_next;
    range_t           hi_reg, hi_next;
    logic             hi_found_reg, hi_found_next;
    logic             dup_reg, dup_next;

    // Walker: source index, remaining reads, direction
    logic [IDX_W-1:0] src_reg, src_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic             asc_reg, asc_next;
    logic             rvld_reg, rvld_next;
    logic [IDX_W-1:0] ridx_reg, ridx_next;

    // Final write after the shift pass
    logic             fin_we_reg, fin_we_next;
    logic [IDX_W-1:0] fin_addr_reg, fin_addr_next;
    range_t           fin_data_reg, fin_data_next;

    logic [31:0]      prev_start_reg, prev_start_next;
    art_out_t         out_reg, out_next;
    logic             out_vld_reg, out_vld_next;

    // Memory ports
    range_t           mem [MAX_RANGES];
    range_t           rdata_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    range_t           mem_wdata;

    logic             walking;
    logic             rd_en;
    logic             walk_done;
    logic             adj_lo;
    logic             adj_hi;
    logic             full;
    logic             in_lo;
    logic             in_hi;
    logic [IDX_W-1:0] k_idx;
    logic [IDX_W-1:0] km1;
    logic [IDX_W-1:0] top;

    // Range memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Walker status
    assign walking   = (state_reg == ST_SCAN) || (state_reg == ST_SHIFT) ||
                       (state_reg == ST_EMIT);
    assign rd_en     = walking && (rem_reg != '0);
    assign rd_addr   = src_reg;
    assign walk_done = (rem_reg == '0) && !rvld_reg;

    // Decision terms; adjacency compares run at 33 bits so there is no wrap
    assign adj_lo = (k_reg != '0) &&
                    (({1'b0, lo_reg.rend} + 33'd1) == {1'b0, in_reg.packet_number});
    assign adj_hi = hi_found_reg &&
                    (({1'b0, in_reg.packet_number} + 33'd1) == {1'b0, hi_reg.rstart});
    assign full   = (n_reg >= CNT_W'(MAX_RANGES));
    assign k_idx  = k_reg[IDX_W-1:0];
    assign km1    = IDX_W'(k_reg - CNT_W'(1));
    assign top    = IDX_W'(n_reg - CNT_W'(1));
    assign in_lo  = (rdata_reg.rstart <= in_reg.packet_number);
    assign in_hi  = (in_reg.packet_number <= rdata_reg.rend);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (walk_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (walk_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (in_reg.ack_eliciting && (n_reg != '0))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (walk_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        in_next         = in_reg;
        n_next          = n_reg;
        st_next         = st_reg;
        k_next          = k_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        hi_found_next   = hi_found_reg;
        dup_next        = dup_reg;
        src_next        = src_reg;
        rem_next        = rem_reg;
        asc_next        = asc_reg;
        rvld_next       = 1'b0;
        ridx_next       = ridx_reg;
        fin_we_next     = fin_we_reg;
        fin_addr_next   = fin_addr_reg;
        fin_data_next   = fin_data_reg;
        prev_start_next = prev_start_reg;
        out_next        = out_reg;
        out_vld_next    = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = rdata_reg;

        // Walker advance, one read per cycle
        if (rd_en)
        begin
            rvld_next = 1'b1;
            ridx_next = src_reg;
            src_next  = asc_reg ? (src_reg + IDX_W'(1)) : (src_reg - IDX_W'(1));
            rem_next  = rem_reg - CNT_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    in_next       = cmd;
                    k_next        = '0;
                    hi_found_next = 1'b0;
                    dup_next      = 1'b0;
                    src_next      = '0;
                    rem_next      = n_reg;
                    asc_next      = 1'b1;
                end
            end

            // Scan: find duplicate, the range below and the range above
            ST_SCAN:
            begin
                if (rvld_reg)
                begin
                    if (in_lo && in_hi)
                    begin
                        dup_next = 1'b1;
                    end
                    if (!in_hi)
                    begin
                        k_next  = CNT_W'(ridx_reg) + CNT_W'(1);
                        lo_next = rdata_reg;
                    end
                    else if (!hi_found_reg)
                    begin
                        hi_next       = rdata_reg;
                        hi_found_next = 1'b1;
                    end
                end
            end

            // Pick the update and set up the shift pass
            ST_UPDATE:
            begin
                rem_next    = '0;
                fin_we_next = 1'b0;
                st_next     = UPD_EXT;
                if (dup_reg)
                begin
                    st_next = UPD_DUP;
                end
                else if (adj_lo && adj_hi)
                begin
                    st_next       = UPD_MERGE;
                    fin_we_next   = 1'b1;
                    fin_addr_next = km1;
                    fin_data_next = '{rstart: lo_reg.rstart, rend: hi_reg.rend};
                    asc_next      = 1'b1;
                    src_next      = k_idx + IDX_W'(1);
                    rem_next      = n_reg - CNT_W'(1) - k_reg;
                    n_next        = n_reg - CNT_W'(1);
                end
                else if (adj_lo)
                begin
                    fin_we_next   = 1'b1;
                    fin_addr_next = km1;
                    fin_data_next = '{rstart: lo_reg.rstart, rend: in_reg.packet_number};
                end
                else if (adj_hi)
                begin
                    fin_we_next   = 1'b1;
                    fin_addr_next = k_idx;
                    fin_data_next = '{rstart: in_reg.packet_number, rend: hi_reg.rend};
                end
                else if (full)
                begin
                    st_next = UPD_FULL;
                    if (k_reg != '0)
                    begin
                        fin_we_next   = 1'b1;
                        fin_addr_next = km1;
                        fin_data_next = '{rstart: in_reg.packet_number,
                                          rend: in_reg.packet_number};
                        asc_next      = 1'b1;
                        src_next      = IDX_W'(1);
                        rem_next      = k_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    st_next       = UPD_NEW;
                    fin_we_next   = 1'b1;
                    fin_addr_next = k_idx;
                    fin_data_next = '{rstart: in_reg.packet_number,
                                      rend: in_reg.packet_number};
                    asc_next      = 1'b0;
                    src_next      = IDX_W'(n_reg - CNT_W'(1));
                    rem_next      = n_reg - k_reg;
                    n_next        = n_reg + CNT_W'(1);
                end
            end

            // Shift pass: move each entry one place down or up
            ST_SHIFT:
            begin
                if (rvld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = asc_reg ? (ridx_reg - IDX_W'(1)) : (ridx_reg + IDX_W'(1));
                    mem_wdata = rdata_reg;
                end
            end

            // Final write, then set up the descending emit walk
            ST_FIN:
            begin
                if (fin_we_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = fin_addr_reg;
                    mem_wdata = fin_data_reg;
                end
                asc_next = 1'b0;
                src_next = top;
                rem_next = n_reg;
            end

            // Emit: header from the top range, then one word per lower range
            ST_EMIT:
            begin
                if (rvld_reg)
                begin
                    out_vld_next           = 1'b1;
                    prev_start_next        = rdata_reg.rstart;
                    out_next               = '0;
                    out_next.update_status = st_reg;
                    out_next.last_item     = (ridx_reg == '0);
                    if (ridx_reg == top)
                    begin
                        out_next.item_kind          = KIND_HDR;
                        out_next.largest_ack        = rdata_reg.rend;
                        out_next.ack_range_count    = 6'(n_reg - CNT_W'(1));
                        out_next.first_range_length = rdata_reg.rend - rdata_reg.rstart;
                    end
                    else
                    begin
                        out_next.item_kind    = KIND_RANGE;
                        out_next.gap_size     = prev_start_reg - 32'd1 - rdata_reg.rend;
                        out_next.range_length = rdata_reg.rend - rdata_reg.rstart;
                    end
                end
            end

            default:
            begin
                rem_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            n_reg       <= '0;
            rem_reg     <= '0;
            rvld_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
            fin_we_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            rem_reg     <= rem_next;
            rvld_reg    <= rvld_next;
            out_vld_reg <= out_vld_next;
            fin_we_reg  <= fin_we_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_reg         <= in_next;
        st_reg         <= st_next;
        k_reg          <= k_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        hi_found_reg   <= hi_found_next;
        dup_reg        <= dup_next;
        src_reg        <= src_next;
        asc_reg        <= asc_next;
        ridx_reg       <= ridx_next;
        fin_addr_reg   <= fin_addr_next;
        fin_data_reg   <= fin_data_next;
        prev_start_reg <= prev_start_next;
        out_reg        <= out_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = out_vld_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    // Range count never exceeds the list depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(MAX_RANGES))
        else $error("range count above list depth");

    // A result word only follows a cycle of the emit pass
    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_EMIT))
        else $error("result strobe outside emit pass");

    // Header count is one less than the stored range count
    a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.item_kind == KIND_HDR)) |->
            (result.ack_range_count == 6'(n_reg - CNT_W'(1))))
        else $error("header range count mismatch");

    // An accepted word makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");
`endif

endmodule
